// ===== design/waypoint_heading_follower_core_defines.svh =====
// Assertion macros used by the checker file of the waypoint follower.
// Depends on nothing; included by the checker by its bare file name.
`ifndef WAYPOINT_HEADING_FOLLOWER_CORE_DEFINES_SVH
`define WAYPOINT_HEADING_FOLLOWER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("waypoint follower check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waypoint follower check failed");

`endif

// ===== design/whf_pkg.sv =====
// Types, constants and the CORDIC arctangent table of the waypoint follower.
// Depends on nothing; imported by whf_cordic_step and the top level of the block.
package whf_pkg;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_VEC_INIT,
        S_VEC_ITER,
        S_VEC_MUL,
        S_CHECK,
        S_ERR,
        S_TURN,
        S_ROT_MUL,
        S_ROT_LOAD,
        S_ROT_ITER,
        S_ROT_UPD,
        S_DONE
    } t_state;

    // Control for one pass through the shared CORDIC step.
    typedef struct packed {
        logic       vec_mode;
        logic [4:0] iter;
    } t_cordic_ctl;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DIST_TOL  = 2'd0;
    localparam logic [1:0] REG_ANGLE_TOL = 2'd1;
    localparam logic [1:0] REG_STEP_LEN  = 2'd2;
    localparam logic [1:0] REG_TURN_GAIN = 2'd3;

    // Register reset values.
    localparam logic [30:0] DIST_TOL_RST  = 31'd16384;
    localparam logic [14:0] ANGLE_TOL_RST = 15'd910;
    localparam logic [30:0] STEP_LEN_RST  = 31'd6554;
    localparam logic [15:0] TURN_GAIN_RST = 16'd16384;

    // Inverse CORDIC gain in Q0.16.
    localparam logic signed [16:0] INV_GAIN = 17'sd39797;

    // Saturation limits of the reported counts.
    localparam int MOVE_COUNT_MAX = 8191;
    localparam logic [15:0] TURN_COUNT_MAX = 16'hFFFF;

    // CORDIC working widths.
    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int PW = 54;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [29:0] whf_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/whf_cordic_step.sv =====
// One CORDIC micro-rotation, shared by vectoring and rotation mode.
// Depends on whf_pkg for the control struct and the arctangent table.
module whf_cordic_step
    import whf_pkg::*;
(
    input  t_cordic_ctl           i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [ZW-1:0]  i_z,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [ZW-1:0]  o_z
);

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic                 d_pos;

    // Shifted operands and the angle of this iteration.
    assign xs  = i_x >>> i_ctl.iter;
    assign ys  = i_y >>> i_ctl.iter;
    assign ang = $signed({4'b0, whf_atan(i_ctl.iter)});

    // Vectoring drives y to zero, rotation drives z to zero.
    assign d_pos = i_ctl.vec_mode ? (i_y <= 0) : (i_z >= 0);

    // Counter-clockwise or clockwise micro-rotation.
    always_comb begin
        if (d_pos) begin
            o_x = i_x - ys;
            o_y = i_y + xs;
            o_z = i_z - ang;
        end else begin
            o_x = i_x + ys;
            o_y = i_y - xs;
            o_z = i_z + ang;
        end
    end

endmodule

// ===== design/waypoint_heading_follower_core.sv =====
// Waypoint follower: each request on the input stream is one waypoint; the block drives its
// internal pose there and returns one result with the final pose and step counts. A waypoint
// runs a first bearing, then for each move step the heading corrections, a rotation of the
// step and a new bearing, and then finishes; finishing waits while an earlier result still
// waits at the output. Vectoring and rotation share the one CORDIC step unit, and one
// multiplier serves all products. The block takes no new waypoint until the current one is
// done. Depends on whf_pkg and whf_cordic_step.
module waypoint_heading_follower_core
    import whf_pkg::*;
#(
    parameter int MAX_MOVE_STEPS    = 4096,
    parameter int MAX_TURN_STEPS    = 64,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // target_x [31:0], target_y [63:32]
    input  logic [63:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pose_x [31:0], pose_y [63:32], heading [79:64], move_steps [92:80],
    // turn_steps [108:93], limit_hit [109], zero [111:110]
    output logic [111:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata
);

    localparam int IW  = $clog2(CORDIC_ITERATIONS);
    localparam int MW  = $clog2(MAX_MOVE_STEPS + 1);
    localparam int TW  = $clog2(MAX_TURN_STEPS + 1);
    localparam int OW  = (MW > 13) ? MW : 13;

    t_state n_state, r_state;

    logic [30:0] r_dist_tol;
    logic [14:0] r_angle_tol;
    logic [30:0] r_step_len;
    logic [15:0] r_turn_gain;

    logic signed [31:0]    r_tx, r_ty, r_px, r_py;
    logic [15:0]           r_head, r_bear;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [IW-1:0]         r_iter;
    logic signed [PW-1:0]  r_prod;
    logic [MW-1:0]         r_moves;
    logic [TW-1:0]         r_phase;
    logic [15:0]           r_turns;
    logic                  r_limit;
    logic                  r_ov;
    logic [111:0]          r_odata;

    t_cordic_ctl           ctl;
    logic signed [XW-1:0]  c_x, c_y;
    logic signed [ZW-1:0]  c_z;
    logic signed [36:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [15:0]    err;
    logic signed [17:0]    err_w;
    logic                  err_big;
    logic                  iter_last;
    logic                  too_far;
    logic signed [32:0]    dx, dy;
    logic signed [ZW-1:0]  zr;
    logic signed [ZW-1:0]  z0;
    logic signed [XW-1:0]  len;
    logic signed [PW-1:0]  turn_t;
    logic signed [35:0]    sum_x, sum_y;
    logic [OW-1:0]         mv_ext;
    logic [12:0]           mv_out;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Shared CORDIC step.
    assign ctl.vec_mode = (r_state == S_VEC_ITER);
    assign ctl.iter     = 5'(r_iter);

    whf_cordic_step u_step (
        .i_ctl (ctl),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .o_x   (c_x),
        .o_y   (c_y),
        .o_z   (c_z)
    );

    // Heading error against the bearing, and its tolerance test.
    assign err     = $signed(r_bear - r_head);
    assign err_w   = 18'(err);
    assign err_big = (err_w > $signed({3'b0, r_angle_tol}))
                  || (-err_w > $signed({3'b0, r_angle_tol}));

    assign iter_last = (r_iter == IW'(CORDIC_ITERATIONS - 1));
    assign too_far   = $signed(r_prod[PW-1:16]) > $signed({7'b0, r_dist_tol});

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = 37'(r_x);
        mul_b = INV_GAIN;
        case (r_state)
            S_ERR: begin
                mul_a = 37'(err);
                mul_b = $signed({1'b0, r_turn_gain});
            end
            S_ROT_MUL: begin
                mul_a = $signed({6'b0, r_step_len});
            end
            default: begin
                mul_a = 37'(r_x);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Datapath helpers.
    assign dx     = 33'(r_tx) - 33'(r_py - r_py + r_px);
    assign dy     = 33'(r_ty) - 33'(r_py);
    assign zr     = r_z + ZW'(32'h8000);
    assign z0     = ZW'($signed({r_head, 16'b0}));
    assign len    = XW'(r_prod[PW-1:16]);
    assign turn_t = r_prod + PW'(16384);
    assign sum_x  = 36'(r_px) + r_x;
    assign sum_y  = 36'(r_py) + r_y;
    assign mv_ext = OW'(r_moves);
    assign mv_out = (mv_ext > OW'(MOVE_COUNT_MAX)) ? 13'(MOVE_COUNT_MAX) : mv_ext[12:0];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_s_axis_tvalid) n_state = S_VEC_INIT;
            S_VEC_INIT: n_state = S_VEC_ITER;
            S_VEC_ITER: if (iter_last) n_state = S_VEC_MUL;
            S_VEC_MUL:  n_state = S_CHECK;
            S_CHECK: begin
                if (!too_far || r_moves >= MW'(MAX_MOVE_STEPS)) n_state = S_DONE;
                else n_state = S_ERR;
            end
            S_ERR: begin
                if (!err_big) n_state = S_ROT_MUL;
                else if (r_phase >= TW'(MAX_TURN_STEPS)) n_state = S_DONE;
                else n_state = S_TURN;
            end
            S_TURN:     n_state = S_ERR;
            S_ROT_MUL:  n_state = S_ROT_LOAD;
            S_ROT_LOAD: n_state = S_ROT_ITER;
            S_ROT_ITER: if (iter_last) n_state = S_ROT_UPD;
            S_ROT_UPD:  n_state = S_VEC_INIT;
            S_DONE:     if (!r_ov || i_m_axis_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Port outputs.
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = r_ov;
        o_m_axis_tdata  = r_odata;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
            r_head      <= '0;
            r_dist_tol  <= DIST_TOL_RST;
            r_angle_tol <= ANGLE_TOL_RST;
            r_step_len  <= STEP_LEN_RST;
            r_turn_gain <= TURN_GAIN_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_ov || i_m_axis_tready)) r_ov <= 1'b1;
            else if (r_ov && i_m_axis_tready) r_ov <= 1'b0;
            if (r_state == S_TURN) r_head <= r_head + turn_t[30:15];
            if (r_state == S_ROT_UPD) begin
                r_px <= sat32(sum_x);
                r_py <= sat32(sum_y);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DIST_TOL:  r_dist_tol  <= i_cfg_wdata;
                    REG_ANGLE_TOL: r_angle_tol <= i_cfg_wdata[14:0];
                    REG_STEP_LEN:  r_step_len  <= i_cfg_wdata;
                    REG_TURN_GAIN: r_turn_gain <= i_cfg_wdata[15:0];
                    default:       r_turn_gain <= r_turn_gain;
                endcase
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tx    <= $signed(i_s_axis_tdata[31:0]);
                r_ty    <= $signed(i_s_axis_tdata[63:32]);
                r_moves <= '0;
                r_turns <= '0;
                r_limit <= 1'b0;
            end
            S_VEC_INIT: begin
                r_iter <= '0;
                if (dx < 0) begin
                    r_x <= -XW'(dx);
                    r_y <= -XW'(dy);
                    r_z <= ZW'(33'sh080000000);
                end else begin
                    r_x <= XW'(dx);
                    r_y <= XW'(dy);
                    r_z <= '0;
                end
            end
            S_VEC_ITER, S_ROT_ITER: begin
                r_x    <= c_x;
                r_y    <= c_y;
                r_z    <= c_z;
                r_iter <= r_iter + 1'b1;
            end
            S_VEC_MUL: begin
                r_prod <= mul_p;
                r_bear <= zr[31:16];
            end
            S_CHECK: begin
                r_phase <= '0;
                if (too_far && r_moves >= MW'(MAX_MOVE_STEPS)) r_limit <= 1'b1;
            end
            S_ERR: begin
                r_prod <= mul_p;
                if (err_big && r_phase >= TW'(MAX_TURN_STEPS)) r_limit <= 1'b1;
            end
            S_TURN: begin
                r_phase <= r_phase + 1'b1;
                if (r_turns != TURN_COUNT_MAX) r_turns <= r_turns + 1'b1;
            end
            S_ROT_MUL: begin
                r_prod <= mul_p;
            end
            S_ROT_LOAD: begin
                r_iter <= '0;
                r_y    <= '0;
                if (z0 > ZW'(32'sh40000000)) begin
                    r_z <= z0 - ZW'(33'sh080000000);
                    r_x <= -len;
                end else if (z0 < -ZW'(32'sh40000000)) begin
                    r_z <= z0 + ZW'(33'sh080000000);
                    r_x <= -len;
                end else begin
                    r_z <= z0;
                    r_x <= len;
                end
            end
            S_ROT_UPD: begin
                r_moves <= r_moves + 1'b1;
            end
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    r_odata <= {2'b0, r_limit, r_turns, mv_out, r_head, r_py, r_px};
                end
            end
            default: begin
                r_iter <= r_iter;
            end
        endcase
    end

endmodule

// ===== design/whf_checker.sv =====
// Port-level checker of the waypoint follower, bound to the top level.
// Depends on the assertion macros in waypoint_heading_follower_core_defines.svh.
`include "waypoint_heading_follower_core_defines.svh"

module whf_checker #(
    parameter int MAX_MOVE_STEPS = 4096
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [111:0] o_m_axis_tdata
);

    // A stalled result stays offered.
    `WHF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // An accepted waypoint makes the block busy.
    `WHF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // The move count never passes its limit.
    `WHF_ASSERT_IMPL(a_moves, i_clk, i_rst_n, o_m_axis_tvalid, 32'(o_m_axis_tdata[92:80]) <= MAX_MOVE_STEPS)

endmodule

bind waypoint_heading_follower_core whf_checker #(
    .MAX_MOVE_STEPS (MAX_MOVE_STEPS)
) u_whf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
